>>> src/nsfc_pkg.sv
package nsfc_pkg;

    localparam int HEADER_LEN = 6;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int KIND_W     = 3;

    localparam logic [COUNT_W-1:0] MAX_LINE_LEN_RST = 8'd128;

    // sentence kind codes
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GPRMC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GPGSA = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GPGGA = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PMT   = 3'd4;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;

    typedef logic [CHAR_W-1:0] t_char;
    typedef t_char [HEADER_LEN-1:0] t_header;

    localparam t_header HDR_GPRMC = {8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24};
    localparam t_header HDR_GPGSA = {8'h41, 8'h53, 8'h47, 8'h50, 8'h47, 8'h24};
    localparam t_header HDR_GPGGA = {8'h41, 8'h47, 8'h47, 8'h50, 8'h47, 8'h24};
    localparam t_char   CH_P = 8'h50;
    localparam t_char   CH_M = 8'h4D;
    localparam t_char   CH_T = 8'h54;

    // one finished line as seen by the output stage
    typedef struct packed {
        logic                has_result;
        logic [KIND_W-1:0]   sentence_kind;
        logic                checksum_ok;
        logic [COUNT_W-1:0]  line_length;
        logic [CHAR_W-1:0]   computed_checksum;
    } t_line_result;

    function automatic t_char hex_upper(input logic [3:0] nib);
        t_char c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h41 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> src/nsfc_if.sv
interface nsfc_in_if;
    import nsfc_pkg::*;
    logic  valid;
    logic  ready;
    t_char rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfc_out_if;
    import nsfc_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   sentence_kind;
    logic                checksum_ok;
    logic [COUNT_W-1:0]  line_length;
    logic [CHAR_W-1:0]   computed_checksum;

    modport source (output valid, output sentence_kind, output checksum_ok,
                    output line_length, output computed_checksum, input ready);
    modport sink   (input valid, input sentence_kind, input checksum_ok,
                    input line_length, input computed_checksum, output ready);
endinterface

>>> src/nsfc_line_tracker.sv
module nsfc_line_tracker
    import nsfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_char              i_byte,
    input  logic [COUNT_W-1:0] i_max_len,
    output t_line_result       o_result
);

    t_header            r_hdr,       n_hdr;
    logic [COUNT_W-1:0] r_count,     n_count;
    t_char              r_xor,       n_xor;
    logic               r_dollar,    n_dollar;
    logic               r_star,      n_star;
    logic               r_nul,       n_nul;
    logic [1:0]         r_dcnt,      n_dcnt;
    t_char              r_d0,        n_d0;
    t_char              r_d1,        n_d1;

    logic [KIND_W-1:0]  w_kind;
    logic               w_ok;
    logic               w_eol;

    always_comb begin
        if (r_hdr == HDR_GPRMC) begin
            w_kind = KIND_GPRMC;
        end else if (r_hdr == HDR_GPGSA) begin
            w_kind = KIND_GPGSA;
        end else if (r_hdr == HDR_GPGGA) begin
            w_kind = KIND_GPGGA;
        end else if (r_hdr[1] == CH_P && r_hdr[2] == CH_M && r_hdr[3] == CH_T) begin
            w_kind = KIND_PMT;
        end else begin
            w_kind = KIND_OTHER;
        end
    end

    assign w_ok = r_star && (r_xor != '0) && (r_dcnt >= 2'd2)
                  && (r_d0 == hex_upper(r_xor[7:4]))
                  && (r_d1 == hex_upper(r_xor[3:0]));

    assign w_eol = (i_byte == CH_CR) || (i_byte == CH_LF);

    always_comb begin
        o_result.has_result        = i_adv && w_eol && (r_count != '0);
        o_result.sentence_kind     = w_kind;
        o_result.checksum_ok       = w_ok;
        o_result.line_length       = r_count;
        o_result.computed_checksum = r_xor;
    end

    always_comb begin
        n_hdr    = r_hdr;
        n_count  = r_count;
        n_xor    = r_xor;
        n_dollar = r_dollar;
        n_star   = r_star;
        n_nul    = r_nul;
        n_dcnt   = r_dcnt;
        n_d0     = r_d0;
        n_d1     = r_d1;
        if (!w_eol) begin
            if (r_count < COUNT_W'(HEADER_LEN)) begin
                n_hdr[r_count[2:0]] = i_byte;
            end
            // checksum scan, frozen after a nul
            if (!r_nul) begin
                if (i_byte == CH_NUL) begin
                    n_nul = 1'b1;
                end else if (i_byte == CH_DOLLAR) begin
                    n_dollar = 1'b1;
                end else if (i_byte == CH_STAR) begin
                    n_star = r_dollar;
                end else if (r_dollar) begin
                    if (!r_star) begin
                        n_xor = r_xor ^ i_byte;
                    end else begin
                        if (r_dcnt == 2'd0) begin
                            n_d0 = i_byte;
                        end
                        if (r_dcnt == 2'd1) begin
                            n_d1 = i_byte;
                        end
                        if (r_dcnt != 2'd3) begin
                            n_dcnt = r_dcnt + 2'd1;
                        end
                    end
                end
            end
            n_count = r_count + COUNT_W'(1);
        end
        // line end or overlong line starts a fresh line
        if (w_eol || (n_count >= i_max_len)) begin
            n_hdr    = '0;
            n_count  = '0;
            n_xor    = '0;
            n_dollar = 1'b0;
            n_star   = 1'b0;
            n_nul    = 1'b0;
            n_dcnt   = '0;
            n_d0     = '0;
            n_d1     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= '0;
            r_count  <= '0;
            r_xor    <= '0;
            r_dollar <= 1'b0;
            r_star   <= 1'b0;
            r_nul    <= 1'b0;
            r_dcnt   <= '0;
            r_d0     <= '0;
            r_d1     <= '0;
        end else if (i_adv) begin
            r_hdr    <= n_hdr;
            r_count  <= n_count;
            r_xor    <= n_xor;
            r_dollar <= n_dollar;
            r_star   <= n_star;
            r_nul    <= n_nul;
            r_dcnt   <= n_dcnt;
            r_d0     <= n_d0;
            r_d1     <= n_d1;
        end
    end

endmodule

>>> src/nmea_sentence_framer_checker.sv
// a line-ending byte passes the input register and then the result register before its result is offered
// throughput: one byte per cycle, sustained; only a line end waits while a result is held
// the line state updates once per byte in a single pass of short logic
// reset (synchronous, active low): empties both stages, clears the line state,
// and sets max_line_len back to 128
module nmea_sentence_framer_checker
    import nsfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    nsfc_in_if.sink            i_in,
    nsfc_out_if.source         o_out,
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data
);

    // configuration register
    logic [COUNT_W-1:0] r_max_len;

    // input stage
    logic  r_in_valid;
    t_char r_in_byte;

    // output stage
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic               r_out_ok;
    logic [COUNT_W-1:0] r_out_len;
    logic [CHAR_W-1:0]  r_out_xor;

    logic         w_adv;
    logic         w_out_free;
    logic         w_in_eol;
    t_line_result w_result;

    // the output register can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || o_out.ready;
    // only a line end can produce a result
    assign w_in_eol   = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    // the held byte is processed unless it ends a line and the result side is full
    assign w_adv      = r_in_valid && (w_out_free || !w_in_eol);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LINE_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    // input register, refilled on every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // per-line header, counter and checksum scan
    nsfc_line_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_result  (w_result)
    );

    // result register: loads a finished line, else empties once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_result.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.has_result) begin
            r_out_kind <= w_result.sentence_kind;
            r_out_ok   <= w_result.checksum_ok;
            r_out_len  <= w_result.line_length;
            r_out_xor  <= w_result.computed_checksum;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.sentence_kind     = r_out_kind;
    assign o_out.checksum_ok       = r_out_ok;
    assign o_out.line_length       = r_out_len;
    assign o_out.computed_checksum = r_out_xor;

endmodule

>>> verif/nmea_sentence_framer_checker_tb.sv
module nmea_sentence_framer_checker_tb;
    import nsfc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_HOLD     = 400;
    localparam logic [127:0] HEX_UP = "0123456789ABCDEF";

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               ok;
        logic [COUNT_W-1:0] len;
        t_char              csum;
    } t_line_fields;

    typedef struct packed {
        t_char        b;
        logic         has_exp;
        t_line_fields exp;
    } t_dir_row;

    // directed bytes: empty line end, a good rmc sentence, repeated dollar with a
    // zero checksum, pmt kind with nul and an all-ones byte
    localparam t_dir_row DIR_ROWS [26] = '{
        '{CH_LF,     1'b0, '0},
        '{CH_DOLLAR, 1'b0, '0},
        '{"G",       1'b0, '0},
        '{"P",       1'b0, '0},
        '{"R",       1'b0, '0},
        '{"M",       1'b0, '0},
        '{"C",       1'b0, '0},
        '{CH_STAR,   1'b0, '0},
        '{"4",       1'b0, '0},
        '{"B",       1'b0, '0},
        '{CH_CR,     1'b1, '{KIND_GPRMC, 1'b1, 8'd9, 8'h4B}},
        '{CH_DOLLAR, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, '0},
        '{"A",       1'b0, '0},
        '{"A",       1'b0, '0},
        '{CH_STAR,   1'b0, '0},
        '{"0",       1'b0, '0},
        '{"0",       1'b0, '0},
        '{CH_LF,     1'b1, '{KIND_OTHER, 1'b0, 8'd7, 8'h00}},
        '{"x",       1'b0, '0},
        '{"P",       1'b0, '0},
        '{"M",       1'b0, '0},
        '{"T",       1'b0, '0},
        '{CH_NUL,    1'b0, '0},
        '{8'hFF,     1'b0, '0},
        '{CH_LF,     1'b1, '{KIND_PMT, 1'b0, 8'd6, 8'h00}}
    };

    // max line length per phase and bytes sent in it; phase 6 gets a random value
    localparam logic [7:0] PHASE_MAX [NUM_PHASES] =
        '{8'd255, 8'd8, 8'd0, 8'd1, 8'd7, 8'd40, 8'd128, 8'd128};
    localparam int PHASE_BYTES [NUM_PHASES] = '{260, 110, 30, 30, 50, 200, 230, 250};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [COUNT_W-1:0] i_cfg_wr_data;

    nsfc_in_if  in_if ();
    nsfc_out_if out_if ();

    nmea_sentence_framer_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // line state of the predictor
    t_header            line_hdr;
    logic [COUNT_W-1:0] line_chars;
    t_char              line_xor;
    logic               got_dollar, got_star, got_nul;
    logic [1:0]         n_digits;
    t_char              digit_hi, digit_lo;
    logic [COUNT_W-1:0] max_len;

    t_line_fields pending_lines [$];
    int           mismatch_cnt = 0;
    int           bytes_sent   = 0;
    int           cycle_cnt    = 0;
    int           hold_req     = 0;
    logic         tx_quiet     = 1'b0;

    function automatic t_char hex_char(input logic [3:0] nib);
        return HEX_UP[8*(15-nib) +: 8];
    endfunction

    function automatic void clear_line();
        line_hdr   = '0;
        line_chars = '0;
        line_xor   = '0;
        got_dollar = 1'b0;
        got_star   = 1'b0;
        got_nul    = 1'b0;
        n_digits   = '0;
        digit_hi   = '0;
        digit_lo   = '0;
    endfunction

    // one received byte through the framer; returns 1 when a line is finished
    function automatic logic advance_line(input t_char c, output t_line_fields line);
        line = '0;
        if (c == CH_CR || c == CH_LF) begin
            if (line_chars == 0) return 1'b0;
            if (line_hdr == HDR_GPRMC)      line.kind = KIND_GPRMC;
            else if (line_hdr == HDR_GPGSA) line.kind = KIND_GPGSA;
            else if (line_hdr == HDR_GPGGA) line.kind = KIND_GPGGA;
            else if (line_hdr[1] == CH_P && line_hdr[2] == CH_M && line_hdr[3] == CH_T)
                line.kind = KIND_PMT;
            else
                line.kind = KIND_OTHER;
            line.ok = got_star && line_xor != 0 && n_digits >= 2 &&
                      digit_hi == hex_char(line_xor[7:4]) &&
                      digit_lo == hex_char(line_xor[3:0]);
            line.len  = line_chars;
            line.csum = line_xor;
            clear_line();
            return 1'b1;
        end
        if (line_chars < HEADER_LEN) line_hdr[line_chars[2:0]] = c;
        // checksum scan stops for good at a nul
        if (!got_nul) begin
            if (c == CH_NUL) begin
                got_nul = 1'b1;
            end else if (c == CH_DOLLAR) begin
                got_dollar = 1'b1;
            end else if (c == CH_STAR) begin
                got_star = got_dollar;
            end else if (got_dollar) begin
                if (!got_star) begin
                    line_xor ^= c;
                end else begin
                    if (n_digits == 0) digit_hi = c;
                    else if (n_digits == 1) digit_lo = c;
                    if (n_digits < 3) n_digits++;
                end
            end
        end
        line_chars++;
        if (line_chars >= max_len) clear_line();
        return 1'b0;
    endfunction

    // offer one byte after a random gap and wait for its transaction
    task automatic send_byte(input t_char c, input logic typed, input t_line_fields typed_line);
        int           gap;
        logic         done;
        t_line_fields line;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= c;
        do @(posedge i_clk); while (!in_if.ready);
        done = advance_line(c, line);
        if (typed) pending_lines.push_back(typed_line);
        else if (done) pending_lines.push_back(line);
        bytes_sent++;
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_for_lines();
        while (pending_lines.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_len = v;
    endtask

    // one line: sentences with random content, varied headers and checksum fields, some disrupted,
    // some raw noise
    task automatic emit_sentence();
        t_char seq [$];
        t_char sum, ch, d_hi, d_lo;
        string head;
        int    shape, nbody, i;
        seq   = {};
        sum   = '0;
        head  = "";
        tx_quiet = ($urandom_range(0, 3) == 0);
        shape = $urandom_range(0, 99);
        if (shape < 15) begin
            nbody = $urandom_range(1, 24);
            repeat (nbody) seq.push_back(t_char'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 6))
                0: head = "$GPRMC";
                1: head = "$GPGSA";
                2: head = "$GPGGA";
                3: head = "$PMTK";
                4: head = "$GP";
                5: head = "$";
                default: head = "";
            endcase
            for (i = 0; i < head.len(); i++) begin
                seq.push_back(head[i]);
                if (i > 0) sum ^= head[i];
            end
            nbody = ($urandom_range(0, 39) == 0) ? $urandom_range(0, int'(max_len) + 4)
                                                 : $urandom_range(0, 14);
            repeat (nbody) begin
                do ch = t_char'($urandom_range(8'h20, 8'h7E));
                while (ch == CH_DOLLAR || ch == CH_STAR);
                seq.push_back(ch);
                sum ^= ch;
            end
            d_hi = hex_char(sum[7:4]);
            d_lo = hex_char(sum[3:0]);
            case ($urandom_range(0, 9))
                0: ;  // no checksum field
                1: seq.push_back(CH_STAR);
                2: begin
                    seq.push_back(CH_STAR);
                    seq.push_back(d_hi);
                end
                3: begin
                    // lowercase digits
                    seq.push_back(CH_STAR);
                    seq.push_back(d_hi | 8'h20);
                    seq.push_back(d_lo | 8'h20);
                end
                4: begin
                    if ($urandom_range(0, 1)) d_hi ^= 8'h01;
                    else d_lo ^= 8'h01;
                    seq.push_back(CH_STAR);
                    seq.push_back(d_hi);
                    seq.push_back(d_lo);
                end
                5: begin
                    // trailing characters after the digits
                    seq.push_back(CH_STAR);
                    seq.push_back(d_hi);
                    seq.push_back(d_lo);
                    repeat ($urandom_range(1, 4))
                        seq.push_back(t_char'($urandom_range(8'h20, 8'h7E)));
                end
                default: begin
                    seq.push_back(CH_STAR);
                    seq.push_back(d_hi);
                    seq.push_back(d_lo);
                end
            endcase
            if (shape < 35) begin
                // one disruptive byte anywhere in the line
                case ($urandom_range(0, 3))
                    0: ch = CH_NUL;
                    1: ch = CH_DOLLAR;
                    2: ch = CH_STAR;
                    default: begin
                        do ch = t_char'($urandom_range(0, 255));
                        while (ch == CH_CR || ch == CH_LF);
                    end
                endcase
                seq.insert($urandom_range(0, seq.size()), ch);
            end
        end
        if (shape >= 15 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0: seq.push_back(CH_LF);
                1: begin
                    seq.push_back(CH_CR);
                    seq.push_back(CH_LF);
                end
                default: seq.push_back(CH_CR);
            endcase
        end
        foreach (seq[k]) send_byte(seq[k], 1'b0, '0);
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("nmea_sentence_framer_checker verification failed");
            $finish;
        end
    end

    // result side: random stalls, a long hold on request, check of every transaction
    initial begin : result_sink
        int           n;
        logic         rx_quiet;
        t_line_fields want;
        rx_quiet     = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 11) == 0) rx_quiet = !rx_quiet;
            if (hold_req > 0) n = hold_req;
            else n = rx_quiet ? 0 : $urandom_range(0, 9);
            hold_req = 0;
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            if (pending_lines.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected line kind=%0d ok=%0d len=%0d sum=%02h", $time,
                             out_if.sentence_kind, out_if.checksum_ok, out_if.line_length,
                             out_if.computed_checksum);
            end else begin
                want = pending_lines.pop_front();
                if (out_if.sentence_kind !== want.kind || out_if.checksum_ok !== want.ok ||
                    out_if.line_length !== want.len || out_if.computed_checksum !== want.csum)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: line mismatch exp kind=%0d ok=%0d len=%0d sum=%02h %s",
                                 $time, want.kind, want.ok, want.len, want.csum,
                                 $sformatf("got kind=%0d ok=%0d len=%0d sum=%02h",
                                           out_if.sentence_kind, out_if.checksum_ok,
                                           out_if.line_length, out_if.computed_checksum));
                end
            end
            @(negedge i_clk);
        end
    end

    // byte side: reset, directed bytes, then random phases with new line limits
    initial begin : byte_source
        logic [COUNT_W-1:0] v;
        int                 phase_start;
        logic               paused;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = '0;
        clear_line();
        max_len = MAX_LINE_LEN_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) send_byte(DIR_ROWS[r].b, DIR_ROWS[r].has_exp, DIR_ROWS[r].exp);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // limit only changes once the block is idle
            stop_input();
            wait_for_lines();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            v = (p == 6) ? COUNT_W'($urandom_range(8, 255)) : PHASE_MAX[p];
            write_max_len(v);
            // long result hold so the block backs up into the byte side
            if (p == 5) hold_req = LONG_HOLD;
            phase_start = bytes_sent;
            paused = 1'b0;
            while (bytes_sent < phase_start + PHASE_BYTES[p]) begin
                emit_sentence();
                // in phase 6 the byte side waits once, midway, for every line in flight
                if (p == 6 && !paused && bytes_sent >= phase_start + PHASE_BYTES[p] / 2)
                begin
                    stop_input();
                    wait_for_lines();
                    paused = 1'b1;
                end
            end
        end

        stop_input();
        wait_for_lines();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("nmea_sentence_framer_checker verification clean");
        else
            $display("nmea_sentence_framer_checker verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/nsfc_pkg.sv
src/nsfc_if.sv
src/nsfc_line_tracker.sv
src/nmea_sentence_framer_checker.sv
verif/nmea_sentence_framer_checker_tb.sv
